// ===== rtl/rsrr_pkg.sv =====
// Package for the ring stop request register.
// Operation codes, controller state type and ring size constants.
// No dependencies.
`default_nettype none

package rsrr_pkg;

  localparam int unsigned STOP_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned MAP_W   = 64;

  localparam logic [COUNT_W-1:0] STOP_LIMIT = 7'd64;

  typedef enum logic [2:0] {
    OP_REGISTER = 3'd0,
    OP_DELETE   = 3'd1,
    OP_NEXT     = 3'd2,
    OP_PREVIOUS = 3'd3,
    OP_SET_POS  = 3'd4,
    OP_CLEAR    = 3'd5,
    OP_READ     = 3'd6,
    OP_SET_FLAG = 3'd7
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_ALIGN = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_PUSH  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/ring_stop_request_register_top.sv =====
// Ring stop request register: request set, position and flag, with one-bit-per-cycle rank search.
// Depends on rsrr_pkg.
// Holds the single register stop_count, written over the cfg channel.
// Each item takes one result. Register, delete, next, previous, set position, clear and
// set flag go from acceptance through the execute and push states to the result. A read
// rank item first rotates a copy of the request map one bit per cycle until it lines up
// with the current stop, then scans it one bit per cycle (up to 64 bits, ending at the hit).
// One item is in work at a time. The output register lets the next item enter while a
// result waits. cfg_ready is high while no item is in work.
`default_nettype none

module ring_stop_request_register_top
  import rsrr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] stop_count,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         operation,
  input  wire logic [STOP_W-1:0]  stop_id,
  input  wire logic [STOP_W-1:0]  rank,
  input  wire logic               flag_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [STOP_W-1:0]       current_stop,
  output logic [COUNT_W-1:0]      request_count,
  output logic [STOP_W-1:0]       ranked_stop,
  output logic                    ranked_valid,
  output logic                    at_new_stop,
  output logic                    accepted
);

  state_t              state;
  logic [COUNT_W-1:0]  stop_count_q;
  logic [MAP_W-1:0]    request_map;
  logic [STOP_W-1:0]   position;
  logic                new_stop_flag;
  logic [COUNT_W-1:0]  held;

  op_t                 op_q;
  logic [STOP_W-1:0]   id_q;
  logic [STOP_W-1:0]   rank_q;
  logic                flag_q;

  logic [MAP_W-1:0]    scan_map;
  logic [STOP_W-1:0]   step;
  logic [STOP_W-1:0]   seen;

  logic                res_accepted;
  logic [STOP_W-1:0]   res_stop;
  logic                res_valid;

  logic [COUNT_W-1:0]  eff;
  logic                id_bit;
  logic                id_in_range;
  logic [COUNT_W-1:0]  pos_inc;
  logic                out_free;
  logic [MAP_W-1:0]    id_mask;
  logic                exec_accept;

  always_comb begin
    if (stop_count_q == '0) begin
      eff = 7'd1;
    end else if (stop_count_q > STOP_LIMIT) begin
      eff = STOP_LIMIT;
    end else begin
      eff = stop_count_q;
    end
  end

  assign id_mask     = {{(MAP_W-1){1'b0}}, 1'b1} << id_q;
  assign id_bit      = |(request_map & id_mask);
  assign id_in_range = {1'b0, id_q} < eff;
  assign pos_inc     = {1'b0, position} + 7'd1;
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    case (op_q)
      OP_REGISTER: exec_accept = id_in_range && !id_bit;
      OP_DELETE:   exec_accept = id_bit;
      OP_SET_POS:  exec_accept = id_in_range;
      OP_READ:     exec_accept = 1'b0;
      default:     exec_accept = 1'b1;
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_count_q <= STOP_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      stop_count_q <= stop_count;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_q   <= op_t'(operation);
      id_q   <= stop_id;
      rank_q <= rank;
      flag_q <= flag_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      request_map   <= '0;
      position      <= '0;
      new_stop_flag <= 1'b0;
      held          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (state == ST_PUSH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_accepted <= exec_accept;
          res_stop     <= '0;
          res_valid    <= 1'b0;
          state        <= (op_q == OP_READ) ? ST_ALIGN : ST_PUSH;
          case (op_q)
            OP_REGISTER: begin
              if (exec_accept) begin
                request_map <= request_map | id_mask;
                held        <= held + 7'd1;
              end
            end
            OP_DELETE: begin
              if (exec_accept) begin
                request_map <= request_map & ~id_mask;
                held        <= held - 7'd1;
              end
            end
            OP_NEXT: begin
              position <= (pos_inc >= eff) ? '0 : pos_inc[STOP_W-1:0];
            end
            OP_PREVIOUS: begin
              position <= (position == '0) ? STOP_W'(eff - 7'd1) : position - 6'd1;
            end
            OP_SET_POS: begin
              if (exec_accept) begin
                position <= id_q;
              end
            end
            OP_CLEAR: begin
              request_map <= '0;
              held        <= '0;
            end
            OP_READ: begin
              scan_map <= request_map;
              step     <= '0;
              seen     <= '0;
            end
            default: begin
              new_stop_flag <= flag_q;
            end
          endcase
        end
        ST_ALIGN: begin
          if (step == position) begin
            step  <= '0;
            state <= ST_SCAN;
          end else begin
            scan_map <= {scan_map[0], scan_map[MAP_W-1:1]};
            step     <= step + 6'd1;
          end
        end
        ST_SCAN: begin
          scan_map <= {scan_map[0], scan_map[MAP_W-1:1]};
          step     <= step + 6'd1;
          if (scan_map[0] && seen == rank_q) begin
            res_stop     <= position + step;
            res_valid    <= 1'b1;
            res_accepted <= 1'b1;
            state        <= ST_PUSH;
          end else begin
            if (scan_map[0]) begin
              seen <= seen + 6'd1;
            end
            if (step == '1) begin
              state <= ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && out_free) begin
      current_stop  <= position;
      request_count <= held;
      ranked_stop   <= res_stop;
      ranked_valid  <= res_valid;
      at_new_stop   <= new_stop_flag;
      accepted      <= res_accepted;
    end
  end

`ifndef SYNTHESIS
  a_count_tracks_map: assert property (@(posedge clk) disable iff (rst)
    held == COUNT_W'($countones(request_map)))
    else $error("held count differs from request map");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && step == '1) |=> state != ST_SCAN)
    else $error("scan ran past the ring");

  a_result_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_PUSH)
    else $error("result appeared outside push");

  a_valid_rank_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ranked_valid) |-> accepted)
    else $error("valid rank without accept");

  a_no_item_mid_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ALIGN || state == ST_SCAN) |-> in_stall)
    else $error("item taken during scan");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_ring_stop_request_register_top.sv =====
`timescale 1ns / 1ps
// Testbench for ring_stop_request_register_top: directed and random stop operations,
// checked against an in-bench model of the request set, position and flag.
// Depends on rsrr_pkg and the RTL of the top level.

module tb_ring_stop_request_register_top
  import rsrr_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 115;

  typedef struct packed {
    op_t               op;
    logic [STOP_W-1:0] stop;
    logic [STOP_W-1:0] rank;
    logic              flag;
  } stop_item_t;

  typedef struct packed {
    logic [STOP_W-1:0]  current_stop;
    logic [COUNT_W-1:0] request_count;
    logic [STOP_W-1:0]  ranked_stop;
    logic               ranked_valid;
    logic               at_new_stop;
    logic               accepted;
  } stop_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_stop_count = '0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         operation = '0;
  logic [STOP_W-1:0]  stop_id = '0;
  logic [STOP_W-1:0]  rank = '0;
  logic               flag_value = 1'b0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STOP_W-1:0]  current_stop;
  logic [COUNT_W-1:0] request_count;
  logic [STOP_W-1:0]  ranked_stop;
  logic               ranked_valid;
  logic               at_new_stop;
  logic               accepted;

  // model state
  logic [MAP_W-1:0]   ring_map = '0;
  logic [STOP_W-1:0]  ring_pos = '0;
  logic               ring_flag = 1'b0;
  logic [COUNT_W-1:0] ring_count = 7'd64;

  stop_item_t   pending_items[$];
  stop_result_t expected_results[$];
  stop_item_t   cur_item;

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  ring_stop_request_register_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .stop_count    (cfg_stop_count),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .stop_id       (stop_id),
    .rank          (rank),
    .flag_value    (flag_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .current_stop  (current_stop),
    .request_count (request_count),
    .ranked_stop   (ranked_stop),
    .ranked_valid  (ranked_valid),
    .at_new_stop   (at_new_stop),
    .accepted      (accepted)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [COUNT_W-1:0] ring_size(input logic [COUNT_W-1:0] c);
    if (c == '0) return 7'd1;
    if (c > STOP_LIMIT) return STOP_LIMIT;
    return c;
  endfunction

  task automatic apply_stop_op(input stop_item_t it, output stop_result_t r);
    logic [COUNT_W-1:0] size;
    logic [STOP_W-1:0]  s;
    int                 seen;
    size = ring_size(ring_count);
    r = '0;
    seen = 0;
    case (it.op)
      OP_REGISTER: begin
        if ({1'b0, it.stop} < size && !ring_map[it.stop]) begin
          ring_map[it.stop] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      OP_DELETE: begin
        if (ring_map[it.stop]) begin
          ring_map[it.stop] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      OP_NEXT: begin
        if ({1'b0, ring_pos} + 7'd1 >= size) ring_pos = '0;
        else ring_pos = ring_pos + 6'd1;
        r.accepted = 1'b1;
      end
      OP_PREVIOUS: begin
        if (ring_pos == '0) ring_pos = STOP_W'(size - 7'd1);
        else ring_pos = ring_pos - 6'd1;
        r.accepted = 1'b1;
      end
      OP_SET_POS: begin
        if ({1'b0, it.stop} < size) begin
          ring_pos = it.stop;
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        ring_map = '0;
        r.accepted = 1'b1;
      end
      OP_READ: begin
        for (int k = 0; k < 64; k++) begin
          s = ring_pos + STOP_W'(k);
          if (ring_map[s] && !r.ranked_valid) begin
            if (seen == int'(it.rank)) begin
              r.ranked_stop = s;
              r.ranked_valid = 1'b1;
            end
            seen++;
          end
        end
        r.accepted = r.ranked_valid;
      end
      default: begin
        ring_flag = it.flag;
        r.accepted = 1'b1;
      end
    endcase
    r.current_stop = ring_pos;
    r.request_count = COUNT_W'($countones(ring_map));
    r.at_new_stop = ring_flag;
  endtask

  // sender: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    stop_result_t r;
    if (rst) begin
      in_valid <= 1'b0;
      ring_map = '0;
      ring_pos = '0;
      ring_flag = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_stop_op(cur_item, r);
        expected_results.insert(expected_results.size(), r);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          operation <= cur_item.op;
          stop_id <= cur_item.stop;
          rank <= cur_item.rank;
          flag_value <= cur_item.flag;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall mode redrawn from the cycle counter among none, random and bursty stalls
  always @(posedge clk) begin
    if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 2);
    if (rst || stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_mode == 1) begin
      out_stall <= ($urandom_range(0, 2) == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    stop_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("current_stop", int'(want.current_stop), int'(current_stop));
        check_field("request_count", int'(want.request_count), int'(request_count));
        check_field("ranked_stop", int'(want.ranked_stop), int'(ranked_stop));
        check_field("ranked_valid", int'(want.ranked_valid), int'(ranked_valid));
        check_field("at_new_stop", int'(want.at_new_stop), int'(at_new_stop));
        check_field("accepted", int'(want.accepted), int'(accepted));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_item(input stop_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic stop_item_t make_item(input op_t o, input int s, input int r,
                                           input bit f);
    stop_item_t it;
    it.op = o;
    it.stop = STOP_W'(s);
    it.rank = STOP_W'(r);
    it.flag = f;
    return it;
  endfunction

  task automatic add_random_items(input int unsigned n);
    stop_item_t         it;
    int unsigned        pick;
    logic [COUNT_W-1:0] size;
    size = ring_size(ring_count);
    repeat (n) begin
      it.stop = STOP_W'($urandom_range(0, 63));
      it.rank = STOP_W'($urandom_range(0, 63));
      it.flag = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 30) it.op = OP_REGISTER;
      else if (pick < 42) it.op = OP_DELETE;
      else if (pick < 52) it.op = OP_NEXT;
      else if (pick < 62) it.op = OP_PREVIOUS;
      else if (pick < 70) it.op = OP_SET_POS;
      else if (pick < 73) it.op = OP_CLEAR;
      else if (pick < 93) it.op = OP_READ;
      else it.op = OP_SET_FLAG;
      // mostly in-range stops and low ranks so the set fills and reads hit
      if ($urandom_range(0, 3) != 0) it.stop = STOP_W'($urandom_range(0, size - 1));
      if ($urandom_range(0, 4) < 3) it.rank = STOP_W'($urandom_range(0, 7));
      queue_item(it);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || expected_results.size() > 0 || in_valid);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_stop_count(input logic [COUNT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_stop_count <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    ring_count = v;
  endtask

  initial begin
    logic [COUNT_W-1:0] counts[10];
    counts = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd37, 7'd65, 7'd3, 7'd0, 7'd64};
    counts[8] = COUNT_W'($urandom_range(4, 63));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    queue_item(make_item(OP_READ, 0, 0, 0));
    queue_item(make_item(OP_REGISTER, 0, 0, 0));
    queue_item(make_item(OP_REGISTER, 63, 0, 0));
    queue_item(make_item(OP_REGISTER, 63, 0, 1));
    queue_item(make_item(OP_REGISTER, 31, 0, 0));
    queue_item(make_item(OP_READ, 0, 0, 0));
    queue_item(make_item(OP_READ, 0, 1, 0));
    queue_item(make_item(OP_READ, 0, 2, 0));
    queue_item(make_item(OP_READ, 0, 3, 0));
    queue_item(make_item(OP_READ, 0, 63, 0));
    queue_item(make_item(OP_NEXT, 0, 0, 0));
    queue_item(make_item(OP_PREVIOUS, 0, 0, 0));
    queue_item(make_item(OP_PREVIOUS, 0, 0, 0));
    queue_item(make_item(OP_READ, 0, 0, 0));
    queue_item(make_item(OP_NEXT, 0, 0, 0));
    queue_item(make_item(OP_SET_POS, 63, 0, 0));
    queue_item(make_item(OP_READ, 0, 1, 0));
    queue_item(make_item(OP_SET_POS, 40, 0, 0));
    queue_item(make_item(OP_READ, 0, 1, 0));
    queue_item(make_item(OP_DELETE, 5, 0, 0));
    queue_item(make_item(OP_DELETE, 31, 0, 0));
    queue_item(make_item(OP_SET_FLAG, 0, 0, 1));
    queue_item(make_item(OP_SET_FLAG, 0, 0, 0));
    queue_item(make_item(OP_CLEAR, 0, 0, 0));
    queue_item(make_item(OP_READ, 0, 0, 1));
    wait_drained();

    foreach (counts[i]) begin
      write_stop_count(counts[i]);
      add_random_items(PHASE_ITEMS);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (expected_results.size() > 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
